>>> src/wrv_pkg.sv
package wrv_pkg;

    // One input item.
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] sample_value;
        logic [31:0]        part_count;
        logic signed [31:0] part_mean;
        logic signed [63:0] part_sq_dev;
    } wrv_in_t;

    // One result item.
    typedef struct packed {
        logic [31:0]        sample_count;
        logic signed [31:0] mean_out;
        logic signed [63:0] variance_out;
        logic [31:0]        std_dev_out;
        logic               error_flag;
    } wrv_out_t;

    // Request to the iterative 64 x 64 multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } wrv_mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } wrv_mul_rsp_t;

    // Request to the shared divide and square root unit. The dividend is
    // aligned to the top of the 128-bit word and steps gives the number of result bits.
    typedef struct packed {
        logic         start;
        logic         root_mode;
        logic [127:0] dividend;
        logic [63:0]  divisor;
        logic [7:0]   steps;
    } wrv_div_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] quot;
        logic [31:0]  root;
    } wrv_div_rsp_t;

endpackage

>>> src/wrv_mul.sv
module wrv_mul
    import wrv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  wrv_mul_req_t req,
    output wrv_mul_rsp_t rsp
);

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic         busy_reg;
    logic         done_reg;
    logic [2:0]   step_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    // Pick the operand halves for this partial product.
    always_comb
    begin
        a_half = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
        case (sh_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = '0;
        endcase
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One 32 x 32 product per cycle, added to the accumulator in the next cycle.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
            pp_reg <= a_half * b_half;
            sh_reg <= {1'b0, step_reg[0]} + {1'b0, step_reg[1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

>>> src/wrv_divsqrt.sv
module wrv_divsqrt
    import wrv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  wrv_div_req_t req,
    output wrv_div_rsp_t rsp
);

    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   cnt_reg;
    logic         mode_reg;
    logic [127:0] dq_reg;
    logic [63:0]  r_reg;
    logic [63:0]  d_reg;
    logic [31:0]  root_reg;
    logic [64:0]  lhs;
    logic [64:0]  rhs;
    logic [65:0]  diff;
    logic         ge;

    // One restoring step: a quotient bit, or a root bit from two radicand bits.
    always_comb
    begin
        if (mode_reg)
        begin
            lhs = {r_reg[62:0], dq_reg[127:126]};
            rhs = {31'b0, root_reg, 2'b01};
        end
        else
        begin
            lhs = {r_reg, dq_reg[127]};
            rhs = {1'b0, d_reg};
        end
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = ~diff[65];
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, shifting dividend and partial root.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg   <= req.dividend;
            d_reg    <= req.divisor;
            mode_reg <= req.root_mode;
            r_reg    <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[63:0] : lhs[63:0];
            if (mode_reg)
            begin
                dq_reg   <= {dq_reg[125:0], 2'b00};
                root_reg <= {root_reg[30:0], ge};
            end
            else
            begin
                dq_reg <= {dq_reg[126:0], ge};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dq_reg;
    assign rsp.root = root_reg;

endmodule

>>> src/welford_running_variance_top.sv
// Channel   Direction  Handshake                          Payload
// sample    in         sample_valid / sample_stall        wrv_in_t  sample_data
// result    out        result_valid / result_stall        wrv_out_t result_data
//
// One item at a time runs through a sequencer that drives a 64 x 64 multiplier
// and a divide / square root unit that retires one bit per cycle.
// Clear and set take the shortest path and merge the longest, in which
// the merge's 128-bit divide plus the 64-bit variance divide dominate.
// Reset clears the count, mean and m2 to zero and empties the result register.
// A held result does not block the next item; a finished item waits only while
// the result register is still full and stalled.
module welford_running_variance_top
    import wrv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_stall,
    input  wrv_in_t  sample_data,
    output logic     result_valid,
    input  logic     result_stall,
    output wrv_out_t result_data
);

    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_SET      = 3'd1;
    localparam logic [2:0] OP_ADD      = 3'd2;
    localparam logic [2:0] OP_MERGE    = 3'd3;
    localparam logic [2:0] OP_MULTIPLY = 3'd4;
    localparam logic [2:0] OP_DIVIDE   = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_ADD_MEAN,
        ST_ADD_SQ,
        ST_MRG_Q,
        ST_MRG_MEAN,
        ST_MRG_MM,
        ST_MRG_SQ,
        ST_MRG_DIV,
        ST_MRG_SUM,
        ST_MRG_PART,
        ST_MUL_MEAN,
        ST_MUL_SQ,
        ST_DIV_MEAN,
        ST_DIV_SQ,
        ST_SAT,
        ST_VAR,
        ST_VAR_DONE,
        ST_SD,
        ST_SD_DONE,
        ST_DONE
    } state_t;

    state_t       state_reg;
    state_t       ret_reg;
    wrv_in_t      in_reg;
    logic [31:0]  count_reg;
    logic [31:0]  mean_reg;
    logic [63:0]  m2_reg;
    logic [127:0] t_reg;
    logic [63:0]  mm_reg;
    logic [32:0]  tot_reg;
    logic [32:0]  dmag_reg;
    logic         dneg_reg;
    logic         neg_reg;
    logic         mneg_reg;
    logic         err_reg;
    logic [63:0]  var_reg;
    logic [31:0]  sd_reg;
    logic         res_valid_reg;
    wrv_out_t     res_reg;
    wrv_mul_req_t mul_req_reg;
    wrv_div_req_t div_req_reg;
    wrv_mul_rsp_t mul_rsp;
    wrv_div_rsp_t div_rsp;

    logic [31:0]  x_mag;
    logic [31:0]  mean_mag;
    logic [63:0]  m2_mag;
    logic [31:0]  sub_src;
    logic [32:0]  diff33;
    logic [32:0]  diff_mag;
    logic [32:0]  n_val;
    logic [32:0]  q33;
    logic [33:0]  nm34;
    logic [33:0]  e34;
    logic [33:0]  e_mag;
    logic [47:0]  sat_in;
    logic         sat_err;
    logic [31:0]  sat_val;
    logic         t_fits;
    logic [127:0] p_shift;

    // Clamp a signed magnitude to the 32-bit mean range.
    function automatic logic [32:0] sat_mean(input logic neg, input logic [47:0] m);
        logic [32:0] r;
        if (neg)
        begin
            if (m > 48'h0000_8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, -m[31:0]};
        end
        else
        begin
            if (m > 48'h0000_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, m[31:0]};
        end
        return r;
    endfunction

    wrv_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req_reg),
        .rsp   (mul_rsp)
    );

    wrv_divsqrt u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    // Operand magnitudes, differences, the add-sample mean update, mean saturation and the m2 fit check.
    always_comb
    begin
        x_mag    = in_reg.sample_value[31] ? -in_reg.sample_value : in_reg.sample_value;
        mean_mag = mean_reg[31] ? -mean_reg : mean_reg;
        m2_mag   = m2_reg[63] ? -m2_reg : m2_reg;
        sub_src  = (in_reg.operation == OP_MERGE) ? in_reg.part_mean : in_reg.sample_value;
        diff33   = {sub_src[31], sub_src} - {mean_reg[31], mean_reg};
        diff_mag = diff33[32] ? -diff33 : diff33;
        n_val    = (&count_reg) ? {1'b0, count_reg} : {1'b0, count_reg} + 33'd1;
        q33      = div_rsp.quot[32:0];
        nm34     = {{2{mean_reg[31]}}, mean_reg}
                   + (dneg_reg ? -{1'b0, q33} : {1'b0, q33});
        e34      = {{2{in_reg.sample_value[31]}}, in_reg.sample_value} - nm34;
        e_mag    = e34[33] ? -e34 : e34;
        sat_in   = (state_reg == ST_DIV_MEAN) ? div_rsp.quot[47:0] : mul_rsp.prod[63:16];
        {sat_err, sat_val} = sat_mean(neg_reg, sat_in);
        t_fits   = (t_reg[127:63] == {65{t_reg[63]}});
        p_shift  = {16'b0, mul_rsp.prod[127:16]};
    end

    // Sequencer, accumulator state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ret_reg           <= ST_IDLE;
            count_reg         <= '0;
            mean_reg          <= '0;
            m2_reg            <= '0;
            res_valid_reg     <= 1'b0;
            mul_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !result_stall && (state_reg != ST_DONE))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        in_reg    <= sample_data;
                        err_reg   <= 1'b0;
                        state_reg <= ST_START;
                    end
                end

                ST_START:
                begin
                    neg_reg  <= mean_reg[31] ^ in_reg.sample_value[31];
                    mneg_reg <= m2_reg[63] ^ in_reg.sample_value[31];
                    dmag_reg <= diff_mag;
                    dneg_reg <= diff33[32];
                    case (in_reg.operation)
                        OP_CLEAR:
                        begin
                            count_reg <= '0;
                            mean_reg  <= '0;
                            m2_reg    <= '0;
                            state_reg <= ST_VAR;
                        end
                        OP_SET:
                        begin
                            count_reg <= 32'd1;
                            mean_reg  <= in_reg.sample_value;
                            m2_reg    <= '0;
                            state_reg <= ST_VAR;
                        end
                        OP_ADD:
                        begin
                            if (&count_reg)
                                err_reg <= 1'b1;
                            tot_reg               <= n_val;
                            div_req_reg.start     <= 1'b1;
                            div_req_reg.root_mode <= 1'b0;
                            div_req_reg.dividend  <= {diff_mag, 95'b0};
                            div_req_reg.divisor   <= {31'b0, n_val};
                            div_req_reg.steps     <= 8'd33;
                            ret_reg               <= ST_ADD_MEAN;
                            state_reg             <= ST_WAIT;
                        end
                        OP_MERGE:
                        begin
                            if (in_reg.part_count == 32'd0)
                            begin
                                state_reg <= ST_VAR;
                            end
                            else
                            begin
                                tot_reg           <= {1'b0, count_reg}
                                                     + {1'b0, in_reg.part_count};
                                mul_req_reg.start <= 1'b1;
                                mul_req_reg.a     <= {31'b0, diff_mag};
                                mul_req_reg.b     <= {32'b0, in_reg.part_count};
                                ret_reg           <= ST_MRG_Q;
                                state_reg         <= ST_WAIT;
                            end
                        end
                        OP_MULTIPLY:
                        begin
                            mul_req_reg.start <= 1'b1;
                            mul_req_reg.a     <= {32'b0, mean_mag};
                            mul_req_reg.b     <= {32'b0, x_mag};
                            ret_reg           <= ST_MUL_MEAN;
                            state_reg         <= ST_WAIT;
                        end
                        OP_DIVIDE:
                        begin
                            if (in_reg.sample_value == 32'sd0)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_VAR;
                            end
                            else
                            begin
                                div_req_reg.start     <= 1'b1;
                                div_req_reg.root_mode <= 1'b0;
                                div_req_reg.dividend  <= {mean_mag, 96'b0};
                                div_req_reg.divisor   <= {32'b0, x_mag};
                                div_req_reg.steps     <= 8'd48;
                                ret_reg               <= ST_DIV_MEAN;
                                state_reg             <= ST_WAIT;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_VAR;
                        end
                    endcase
                end

                // The start pulse lasts one cycle; then wait for the unit.
                ST_WAIT:
                begin
                    mul_req_reg.start <= 1'b0;
                    div_req_reg.start <= 1'b0;
                    if (mul_rsp.done || div_rsp.done)
                        state_reg <= ret_reg;
                end

                // Add sample: new mean, then the squared-deviation product.
                ST_ADD_MEAN:
                begin
                    mean_reg          <= nm34[31:0];
                    count_reg         <= tot_reg[31:0];
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.a     <= {31'b0, dmag_reg};
                    mul_req_reg.b     <= {31'b0, e_mag[32:0]};
                    ret_reg           <= ST_ADD_SQ;
                    state_reg         <= ST_WAIT;
                end

                ST_ADD_SQ:
                begin
                    t_reg     <= p_shift + {{64{m2_reg[63]}}, m2_reg};
                    state_reg <= ST_SAT;
                end

                // Merge: mean shift, then the cross term of Chan's formula.
                ST_MRG_Q:
                begin
                    div_req_reg.start     <= 1'b1;
                    div_req_reg.root_mode <= 1'b0;
                    div_req_reg.dividend  <= {mul_rsp.prod[63:0], 64'b0};
                    div_req_reg.divisor   <= {31'b0, tot_reg};
                    div_req_reg.steps     <= 8'd64;
                    ret_reg               <= ST_MRG_MEAN;
                    state_reg             <= ST_WAIT;
                end

                ST_MRG_MEAN:
                begin
                    mean_reg          <= dneg_reg ? mean_reg - div_rsp.quot[31:0]
                                                  : mean_reg + div_rsp.quot[31:0];
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.a     <= {31'b0, dmag_reg};
                    mul_req_reg.b     <= {31'b0, dmag_reg};
                    ret_reg           <= ST_MRG_MM;
                    state_reg         <= ST_WAIT;
                end

                ST_MRG_MM:
                begin
                    mm_reg            <= mul_rsp.prod[63:0];
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.a     <= {32'b0, count_reg};
                    mul_req_reg.b     <= {32'b0, in_reg.part_count};
                    ret_reg           <= ST_MRG_SQ;
                    state_reg         <= ST_WAIT;
                end

                ST_MRG_SQ:
                begin
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.a     <= mm_reg;
                    mul_req_reg.b     <= mul_rsp.prod[63:0];
                    ret_reg           <= ST_MRG_DIV;
                    state_reg         <= ST_WAIT;
                end

                ST_MRG_DIV:
                begin
                    div_req_reg.start     <= 1'b1;
                    div_req_reg.root_mode <= 1'b0;
                    div_req_reg.dividend  <= mul_rsp.prod;
                    div_req_reg.divisor   <= {15'b0, tot_reg, 16'b0};
                    div_req_reg.steps     <= 8'd128;
                    ret_reg               <= ST_MRG_SUM;
                    state_reg             <= ST_WAIT;
                end

                ST_MRG_SUM:
                begin
                    t_reg     <= div_rsp.quot + {{64{m2_reg[63]}}, m2_reg};
                    state_reg <= ST_MRG_PART;
                end

                ST_MRG_PART:
                begin
                    t_reg <= t_reg + {{64{in_reg.part_sq_dev[63]}}, in_reg.part_sq_dev};
                    if (tot_reg[32])
                    begin
                        err_reg   <= 1'b1;
                        count_reg <= '1;
                    end
                    else
                    begin
                        count_reg <= tot_reg[31:0];
                    end
                    state_reg <= ST_SAT;
                end

                // Multiply: scaled mean, then scaled m2.
                ST_MUL_MEAN:
                begin
                    mean_reg          <= sat_val;
                    err_reg           <= err_reg | sat_err;
                    mul_req_reg.start <= 1'b1;
                    mul_req_reg.a     <= m2_mag;
                    mul_req_reg.b     <= {32'b0, x_mag};
                    ret_reg           <= ST_MUL_SQ;
                    state_reg         <= ST_WAIT;
                end

                ST_MUL_SQ:
                begin
                    t_reg     <= mneg_reg ? -p_shift : p_shift;
                    state_reg <= ST_SAT;
                end

                // Divide: scaled mean, then scaled m2.
                ST_DIV_MEAN:
                begin
                    mean_reg              <= sat_val;
                    err_reg               <= err_reg | sat_err;
                    div_req_reg.start     <= 1'b1;
                    div_req_reg.root_mode <= 1'b0;
                    div_req_reg.dividend  <= {m2_mag, 64'b0};
                    div_req_reg.divisor   <= {32'b0, x_mag};
                    div_req_reg.steps     <= 8'd80;
                    ret_reg               <= ST_DIV_SQ;
                    state_reg             <= ST_WAIT;
                end

                ST_DIV_SQ:
                begin
                    t_reg     <= mneg_reg ? -div_rsp.quot : div_rsp.quot;
                    state_reg <= ST_SAT;
                end

                // Clamp the wide m2 result to 64 bits.
                ST_SAT:
                begin
                    if (t_fits)
                    begin
                        m2_reg <= t_reg[63:0];
                    end
                    else
                    begin
                        err_reg <= 1'b1;
                        m2_reg  <= t_reg[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                    end
                    state_reg <= ST_VAR;
                end

                // Report: variance, then standard deviation.
                ST_VAR:
                begin
                    if (count_reg >= 32'd2)
                    begin
                        div_req_reg.start     <= 1'b1;
                        div_req_reg.root_mode <= 1'b0;
                        div_req_reg.dividend  <= {m2_mag, 64'b0};
                        div_req_reg.divisor   <= {32'b0, count_reg - 32'd1};
                        div_req_reg.steps     <= 8'd64;
                        ret_reg               <= ST_VAR_DONE;
                        state_reg             <= ST_WAIT;
                    end
                    else
                    begin
                        var_reg   <= '0;
                        state_reg <= ST_SD;
                    end
                end

                ST_VAR_DONE:
                begin
                    var_reg   <= m2_reg[63] ? -div_rsp.quot[63:0] : div_rsp.quot[63:0];
                    state_reg <= ST_SD;
                end

                ST_SD:
                begin
                    if (!var_reg[63] && (var_reg != 64'd0))
                    begin
                        if (var_reg[62:48] != 15'd0)
                        begin
                            err_reg   <= 1'b1;
                            sd_reg    <= '1;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            div_req_reg.start     <= 1'b1;
                            div_req_reg.root_mode <= 1'b1;
                            div_req_reg.dividend  <= {var_reg[47:0], 80'b0};
                            div_req_reg.divisor   <= '0;
                            div_req_reg.steps     <= 8'd32;
                            ret_reg               <= ST_SD_DONE;
                            state_reg             <= ST_WAIT;
                        end
                    end
                    else
                    begin
                        sd_reg    <= '0;
                        state_reg <= ST_DONE;
                    end
                end

                ST_SD_DONE:
                begin
                    sd_reg    <= div_rsp.root;
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!res_valid_reg || !result_stall)
                    begin
                        res_reg.sample_count <= count_reg;
                        res_reg.mean_out     <= mean_reg;
                        res_reg.variance_out <= var_reg;
                        res_reg.std_dev_out  <= sd_reg;
                        res_reg.error_flag   <= err_reg;
                        res_valid_reg        <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

    // Only one arithmetic unit finishes at a time.
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_rsp.done && div_rsp.done))
        else $error("multiplier and divider finished together");

    // A unit result only arrives while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_rsp.done || div_rsp.done) |-> (state_reg == ST_WAIT))
        else $error("unit result arrived outside the wait state");

    // A unit is started only as the sequencer enters its wait state.
    a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_req_reg.start || div_req_reg.start) |-> (state_reg == ST_WAIT))
        else $error("unit started without waiting for it");

    // A finished item with a free result register shows up next cycle.
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !(res_valid_reg && result_stall))
        |=> (res_valid_reg && state_reg == ST_IDLE))
        else $error("finished item was not delivered");

endmodule

>>> dv/welford_running_variance_top_tb.sv
`timescale 1ns / 100ps

module welford_running_variance_top_tb;
    import wrv_pkg::*;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_MERGE = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_RSV6  = 3'd6;
    localparam logic [2:0] OP_RSV7  = 3'd7;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 20000;

    logic     clk;
    logic     rst_n;
    logic     sample_valid;
    logic     sample_stall;
    wrv_in_t  sample_data;
    logic     result_valid;
    logic     result_stall;
    wrv_out_t result_data;

    welford_running_variance_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Predictor state of the accumulator.
    logic [31:0]        acc_count;
    logic signed [31:0] acc_mean;
    logic signed [63:0] acc_m2;

    wrv_out_t pending_stats[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       timed_out = 1'b0;

    // Directed items with a hand-worked result where one is obvious.
    typedef struct packed {
        wrv_in_t  item;
        logic     has_known;
        wrv_out_t known;
    } directed_row_t;

    directed_row_t directed_rows[$];

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Saturate a signed 128-bit value to 64 bits.
    function automatic logic signed [63:0] clamp_m2(input logic signed [127:0] v,
                                                    inout bit err);
        if (v > 128'sh7FFF_FFFF_FFFF_FFFF)
        begin
            err = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        if (v < -128'sh8000_0000_0000_0000)
        begin
            err = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [31:0] clamp_mean(input logic signed [127:0] v,
                                                      inout bit err);
        if (v > 128'sh7FFF_FFFF)
        begin
            err = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sh8000_0000)
        begin
            err = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Apply one item to the predictor and return the statistics it reports.
    function automatic wrv_out_t update_stats(input wrv_in_t it);
        wrv_out_t res;
        bit err;
        logic signed [127:0] x, d, nm, p, dm, tot, num;
        logic [127:0] mg, q;
        logic [31:0] n;
        logic [63:0] vm;
        logic signed [63:0] var_v;
        err = 1'b0;
        x = it.sample_value;
        case (it.operation)
            OP_CLEAR:
            begin
                acc_count = 0;
                acc_mean = 0;
                acc_m2 = 0;
            end
            OP_SET:
            begin
                acc_count = 1;
                acc_mean = it.sample_value;
                acc_m2 = 0;
            end
            OP_ADD:
            begin
                n = acc_count;
                if (n == 32'hFFFF_FFFF)
                    err = 1'b1;
                else
                    n = n + 1;
                d = x - acc_mean;
                nm = acc_mean + d / $signed({96'd0, n});
                p = d * (x - nm);
                mg = p < 0 ? 128'(-p) : 128'(p);
                mg = mg >> 16;
                p = p < 0 ? -$signed(mg) : $signed(mg);
                acc_m2 = clamp_m2(p + acc_m2, err);
                acc_mean = nm[31:0];
                acc_count = n;
            end
            OP_MERGE:
            begin
                if (it.part_count != 0)
                begin
                    tot = {96'd0, acc_count} + {96'd0, it.part_count};
                    dm = it.part_mean - acc_mean;
                    mg = dm < 0 ? 128'(-dm) : 128'(dm);
                    q = (mg * it.part_count) / tot;
                    num = (mg * mg) * ({96'd0, acc_count} * {96'd0, it.part_count});
                    num = $signed($unsigned(num) / $unsigned(tot << 16));
                    acc_m2 = clamp_m2(num + acc_m2 + it.part_sq_dev, err);
                    acc_mean = dm < 0 ? acc_mean - q[31:0] : acc_mean + q[31:0];
                    if (tot > 128'sh FFFF_FFFF)
                    begin
                        err = 1'b1;
                        acc_count = 32'hFFFF_FFFF;
                    end
                    else
                        acc_count = tot[31:0];
                end
            end
            OP_MUL:
            begin
                p = $signed({64'd0, abs64(acc_mean)} * {64'd0, abs64(x[63:0])} >> 16);
                acc_mean = clamp_mean((acc_mean < 0) != (x < 0) ? -p : p, err);
                p = $signed({64'd0, abs64(acc_m2)} * {64'd0, abs64(x[63:0])} >> 16);
                acc_m2 = clamp_m2((acc_m2 < 0) != (x < 0) ? -p : p, err);
            end
            OP_DIV:
            begin
                if (x == 0)
                    err = 1'b1;
                else
                begin
                    p = $signed(({64'd0, abs64(acc_mean)} << 16) / abs64(x[63:0]));
                    acc_mean = clamp_mean((acc_mean < 0) != (x < 0) ? -p : p, err);
                    p = $signed(({64'd0, abs64(acc_m2)} << 16) / abs64(x[63:0]));
                    acc_m2 = clamp_m2((acc_m2 < 0) != (x < 0) ? -p : p, err);
                end
            end
            default:
            begin
            end
        endcase
        var_v = 0;
        res.std_dev_out = 0;
        if (acc_count >= 2)
        begin
            vm = abs64(acc_m2) / ({32'd0, acc_count} - 64'd1);
            var_v = acc_m2 < 0 ? -$signed(vm) : $signed(vm);
        end
        if (var_v > 0)
        begin
            if (var_v >= 64'sh1_0000_0000_0000)
            begin
                err = 1'b1;
                res.std_dev_out = 32'hFFFF_FFFF;
            end
            else
                res.std_dev_out = 32'(floor_root(64'(var_v) << 16));
        end
        res.sample_count = acc_count;
        res.mean_out = acc_mean;
        res.variance_out = var_v;
        res.error_flag = err;
        return res;
    endfunction

    function automatic wrv_in_t make_item(input logic [2:0] op, input logic [31:0] v,
                                          input logic [31:0] pc, input logic [31:0] pm,
                                          input logic [63:0] pq);
        wrv_in_t it;
        it.operation = op;
        it.sample_value = v;
        it.part_count = pc;
        it.part_mean = pm;
        it.part_sq_dev = pq;
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed(32'($urandom_range(0, 200000))) - 100000;
        endcase
    endfunction

    function automatic wrv_in_t rand_item();
        logic [2:0] op;
        logic [31:0] pc;
        logic [63:0] pq;
        case ($urandom_range(0, 19))
            0: op = OP_CLEAR;
            1, 2: op = OP_SET;
            3, 4, 5, 6, 7, 8, 9, 10, 11: op = OP_ADD;
            12, 13, 14: op = OP_MERGE;
            15, 16: op = OP_MUL;
            17, 18: op = OP_DIV;
            default: op = $urandom_range(0, 1) ? OP_RSV6 : OP_RSV7;
        endcase
        pc = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50);
        pq = $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                       : 64'($urandom_range(0, 1 << 24));
        return make_item(op, $urandom_range(0, 9) == 0 ? 32'd0 : rand_value(),
                         pc, rand_value(), pq);
    endfunction

    // Send one item, holding it until it is accepted.
    task automatic send_item(input wrv_in_t it);
        sample_data <= it;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_burst_gap();
        if ($urandom_range(0, 7) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    endtask

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        wrv_out_t exp_stats;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("unexpected result item");
                error_count++;
            end
            else
            begin
                exp_stats = pending_stats.pop_front();
                if (result_data.sample_count !== exp_stats.sample_count)
                begin
                    $error("sample_count: expected %0d, got %0d",
                           exp_stats.sample_count, result_data.sample_count);
                    error_count++;
                end
                if (result_data.mean_out !== exp_stats.mean_out)
                begin
                    $error("mean_out: expected %0d, got %0d",
                           exp_stats.mean_out, result_data.mean_out);
                    error_count++;
                end
                if (result_data.variance_out !== exp_stats.variance_out)
                begin
                    $error("variance_out: expected %0d, got %0d",
                           exp_stats.variance_out, result_data.variance_out);
                    error_count++;
                end
                if (result_data.std_dev_out !== exp_stats.std_dev_out)
                begin
                    $error("std_dev_out: expected %0d, got %0d",
                           exp_stats.std_dev_out, result_data.std_dev_out);
                    error_count++;
                end
                if (result_data.error_flag !== exp_stats.error_flag)
                begin
                    $error("error_flag: expected %0b, got %0b",
                           exp_stats.error_flag, result_data.error_flag);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: quiet stretches alternate with busy ones.
    always @(negedge clk)
    begin
        int phase;
        phase = ($time / 20000) % 3;
        if (phase == 0)
            result_stall <= 1'b0;
        else if (phase == 1)
            result_stall <= ($urandom_range(0, 3) == 0);
        else
            result_stall <= ($urandom_range(0, 1) == 0);
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("welford_running_variance_top_tb: errors");
            $finish;
        end
    end

    initial begin
        wrv_out_t stats;
        directed_row_t row;
        wrv_out_t zero_stats;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample_data = '0;
        acc_count = 0;
        acc_mean = 0;
        acc_m2 = 0;
        zero_stats = '0;

        // Directed table: the cleared-state rows and the first set row carry a worked result.
        row.has_known = 1'b1;
        row.known = zero_stats;
        row.item = make_item(OP_RSV6, 32'hFFFF_FFFF, '1, '1, '1);
        directed_rows.push_back(row);
        row.item = make_item(OP_CLEAR, '1, '1, '1, '1);
        directed_rows.push_back(row);
        row.item = make_item(OP_MERGE, 32'd5, 32'd0, 32'd7, 64'd9);
        directed_rows.push_back(row);
        row.known.error_flag = 1'b1;
        row.item = make_item(OP_DIV, 32'd0, 0, 0, 0);
        directed_rows.push_back(row);
        row.known = zero_stats;
        row.known.sample_count = 1;
        row.known.mean_out = 32'sh8000_0000;
        row.item = make_item(OP_SET, 32'h8000_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.has_known = 1'b0;
        row.item = make_item(OP_ADD, 32'h7FFF_FFFF, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_ADD, 32'h8000_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_MUL, 32'h7FFF_FFFF, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_DIV, 32'h0000_0001, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_DIV, 32'h8000_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_MERGE, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                             64'h7FFF_FFFF_FFFF_FFFF);
        directed_rows.push_back(row);
        row.item = make_item(OP_ADD, 32'h0001_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_MERGE, 0, 32'h8000_0000, 32'h8000_0000,
                             64'h8000_0000_0000_0000);
        directed_rows.push_back(row);
        row.item = make_item(OP_MUL, 32'h8000_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_MUL, 32'h0000_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_SET, 32'h0003_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_ADD, 32'hFFFD_0000, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(OP_MERGE, 0, 32'd4, 32'h0010_0000, 64'h0004_0000);
        directed_rows.push_back(row);
        row.item = make_item(OP_RSV7, 32'h1234_5678, 0, 0, 0);
        directed_rows.push_back(row);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            stats = update_stats(directed_rows[i].item);
            if (directed_rows[i].has_known && stats !== directed_rows[i].known)
            begin
                $error("row %0d: worked result disagrees with predictor", i);
                error_count++;
            end
            pending_stats.push_back(directed_rows[i].has_known
                                    ? directed_rows[i].known : stats);
            send_item(directed_rows[i].item);
        end

        // Random items in bursts; midway the sender drains the result queue.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            wrv_in_t it;
            if (i == RANDOM_ITEMS / 2)
            begin
                sample_valid <= 1'b0;
                while (pending_stats.size() != 0)
                    @(negedge clk);
            end
            it = rand_item();
            pending_stats.push_back(update_stats(it));
            send_item(it);
            send_burst_gap();
        end
        sample_valid <= 1'b0;

        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);

        if (error_count == 0)
            $display("welford_running_variance_top_tb: clean");
        else
            $display("welford_running_variance_top_tb: errors");
        $finish;
    end

endmodule
